@@ rtl/lsegt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsegt_pkg
// shared constants and types of the min-of-lines segment tree core
// ----------------------------------------------------------------------------
package lsegt_pkg;

   localparam int DOM_BITS    = 20;
   localparam int DOMAIN_SIZE = 1 << DOM_BITS;
   localparam int LEVELS      = DOM_BITS + 1;
   localparam int LVL_W       = 5;
   localparam logic [LVL_W-1:0] LEAF_LVL = LVL_W'(DOM_BITS);

   localparam logic signed [63:0] NOT_FOUND_VALUE = 64'sd100000000000000000;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   // one stored node: valid flag and line
   typedef struct packed {
      logic               valid;
      logic signed [31:0] k;
      logic signed [62:0] b;
   } word_type;

   // request travelling down the row of level cells
   typedef struct packed {
      logic                vld;
      logic                qry;
      logic [DOM_BITS-1:0] pos;
      logic [DOM_BITS-1:0] x;
      logic signed [31:0]  k;
      logic signed [62:0]  b;
      logic signed [63:0]  best;
      logic                found;
   } tok_type;

   typedef struct packed {
      logic                we;
      logic                re;
      logic [DOM_BITS-1:0] addr;
      word_type            wdata;
   } ram_req_type;

   typedef struct packed {
      logic done;
   } cell_stat_type;

endpackage

@@ rtl/min_line_segment_tree_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_line_segment_tree_core
// li chao tree for minimum of lines over 0 .. 2^20-1, one cell per level
// ----------------------------------------------------------------------------
// channel | dir | ports         | content
// req     | in  | req_t*        | insert a line on a segment, or query at x
// rsp     | out | rsp_t*        | least line value at x and found flag
//
// after reset every level store is cleared, no request taken meanwhile
// a query walks 21 cells
// an insert scans two candidate nodes per level and settles each
// covering node, walking down through the cells below it
// one request at a time; a query result waits in the output register
// ----------------------------------------------------------------------------
module min_line_segment_tree_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // slope[31:0], intercept[94:32], seg_low[114:95], seg_high[134:115],
   // query_x[154:135], zero pad[159:155]
   input  logic [159:0] req_tdata,
   // action[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // min_value[63:0]
   output logic [63:0]  rsp_tdata,
   // found[0]
   output logic         rsp_tuser
);
   import lsegt_pkg::*;

   typedef enum logic [5:0] {
      T_CLEAR = 6'b000001,
      T_IDLE  = 6'b000010,
      T_SCAN  = 6'b000100,
      T_WAIT  = 6'b001000,
      T_QWAIT = 6'b010000,
      T_QDONE = 6'b100000
   } tstate_type;

   localparam int PW = DOM_BITS + 3;

   tstate_type            st_ff, st_in;
   logic [DOM_BITS-1:0]   clr_ff, clr_in;
   logic [DOM_BITS-1:0]   lo_ff, lo_in, hi_ff, hi_in;
   logic signed [31:0]    k_ff, k_in;
   logic signed [62:0]    b_ff, b_in;
   logic [LVL_W-1:0]      lvl_ff, lvl_in;
   logic                  side_ff, side_in;
   tok_type               launch_ff, launch_in;
   logic [LVL_W-1:0]      llvl_ff, llvl_in;
   logic signed [63:0]    res_ff, res_in;
   logic                  resf_ff, resf_in;
   logic                  rspv_ff, rspv_in;
   logic [63:0]           rspd_ff, rspd_in;
   logic                  rspu_ff, rspu_in;

   tok_type               cin   [LEVELS];
   tok_type               cout  [LEVELS];
   ram_req_type           creq  [LEVELS];
   word_type              rdat  [LEVELS];
   cell_stat_type         cst   [LEVELS];
   logic                  any_done;

   // request fields
   logic signed [31:0]    f_slope;
   logic signed [62:0]    f_icpt;
   logic [DOM_BITS-1:0]   f_lo, f_hi, f_x;

   assign f_slope = req_tdata[31:0];
   assign f_icpt  = req_tdata[94:32];
   assign f_lo    = req_tdata[114:95];
   assign f_hi    = req_tdata[134:115];
   assign f_x     = req_tdata[154:135];

   // covering node candidates at the scanned level
   logic [LVL_W-1:0] sh;
   logic [PW-1:0]    span, pl, pr, tq, psel, nst, nen, qpar, pst, pen;
   logic             node_in, par_in, side_ok, cand_ok, scan_last;

   assign sh      = LEAF_LVL - lvl_ff;
   assign span    = PW'(1) << sh;
   assign pl      = (PW'(lo_ff) + span - PW'(1)) >> sh;
   assign tq      = (PW'(hi_ff) + PW'(1)) >> sh;
   assign pr      = tq - PW'(1);
   assign psel    = side_ff ? pr : pl;
   assign nst     = psel << sh;
   assign nen     = nst + span - PW'(1);
   assign node_in = (nst >= PW'(lo_ff)) && (nen <= PW'(hi_ff));
   assign qpar    = psel >> 1;
   assign pst     = qpar << (sh + LVL_W'(1));
   assign pen     = pst + (span << 1) - PW'(1);
   // a node whose parent is already covered is not a covering node
   assign par_in  = (lvl_ff != '0) && (pst >= PW'(lo_ff)) && (pen <= PW'(hi_ff));
   assign side_ok = !side_ff || ((tq != '0) && (pr != pl));
   assign cand_ok = node_in && !par_in && side_ok;
   assign scan_last = side_ff && (lvl_ff == LEAF_LVL);

   always_comb begin
      any_done = 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
         any_done = any_done | cst[i].done;
      end
   end

   assign req_tready = (st_ff == T_IDLE);

   always_comb begin
      st_in     = st_ff;
      clr_in    = clr_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      k_in      = k_ff;
      b_in      = b_ff;
      lvl_in    = lvl_ff;
      side_in   = side_ff;
      launch_in = '0;
      llvl_in   = llvl_ff;
      res_in    = res_ff;
      resf_in   = resf_ff;
      rspv_in   = rspv_ff;
      rspd_in   = rspd_ff;
      rspu_in   = rspu_ff;
      if (rspv_ff && rsp_tready) begin
         rspv_in = 1'b0;
      end
      case (st_ff)
         T_CLEAR: begin
            clr_in = clr_ff + DOM_BITS'(1);
            if (clr_ff == '1) begin
               st_in = T_IDLE;
            end
         end
         T_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == ACT_QUERY) begin
                  launch_in.vld  = 1'b1;
                  launch_in.qry  = 1'b1;
                  launch_in.x    = f_x;
                  launch_in.best = NOT_FOUND_VALUE;
                  llvl_in        = '0;
                  st_in          = T_QWAIT;
               end else begin
                  // field width keeps seg_high inside the domain
                  lo_in   = f_lo;
                  hi_in   = f_hi;
                  k_in    = f_slope;
                  b_in    = f_icpt;
                  lvl_in  = '0;
                  side_in = 1'b0;
                  if (f_lo <= f_hi) begin
                     st_in = T_SCAN;
                  end
               end
            end
         end
         T_SCAN: begin
            if (cand_ok) begin
               launch_in.vld = 1'b1;
               launch_in.pos = psel[DOM_BITS-1:0];
               launch_in.k   = k_ff;
               launch_in.b   = b_ff;
               llvl_in       = lvl_ff;
               st_in         = T_WAIT;
            end else if (scan_last) begin
               st_in = T_IDLE;
            end else begin
               side_in = !side_ff;
               if (side_ff) begin
                  lvl_in = lvl_ff + LVL_W'(1);
               end
            end
         end
         T_WAIT: begin
            if (any_done) begin
               if (scan_last) begin
                  st_in = T_IDLE;
               end else begin
                  side_in = !side_ff;
                  if (side_ff) begin
                     lvl_in = lvl_ff + LVL_W'(1);
                  end
                  st_in = T_SCAN;
               end
            end
         end
         T_QWAIT: begin
            if (cout[LEVELS-1].vld) begin
               res_in  = cout[LEVELS-1].found ? cout[LEVELS-1].best : NOT_FOUND_VALUE;
               resf_in = cout[LEVELS-1].found;
               st_in   = T_QDONE;
            end
         end
         T_QDONE: begin
            // hand over once the output register is free
            if (!rspv_ff || rsp_tready) begin
               rspv_in = 1'b1;
               rspd_in = res_ff;
               rspu_in = resf_ff;
               st_in   = T_IDLE;
            end
         end
         default: begin
            st_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= T_CLEAR;
         clr_ff    <= '0;
         launch_ff <= '0;
         rspv_ff   <= 1'b0;
      end else begin
         st_ff     <= st_in;
         clr_ff    <= clr_in;
         launch_ff <= launch_in;
         rspv_ff   <= rspv_in;
      end
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      k_ff    <= k_in;
      b_ff    <= b_in;
      lvl_ff  <= lvl_in;
      side_ff <= side_in;
      llvl_ff <= llvl_in;
      res_ff  <= res_in;
      resf_ff <= resf_in;
      rspd_ff <= rspd_in;
      rspu_ff <= rspu_in;
   end

   assign rsp_tvalid = rspv_ff;
   assign rsp_tdata  = rspd_ff;
   assign rsp_tuser  = rspu_ff;

   // row of level cells, each with its own node store
   for (genvar g = 0; g < LEVELS; g++) begin : g_lvl
      localparam int AW = (g == 0) ? 1 : g;

      logic          m_we;
      logic          m_re;
      logic [AW-1:0] m_addr;
      word_type      m_wdata;
      logic [$bits(word_type)-1:0] m_rdata;

      if (g == 0) begin : g_head
         assign cin[g] = (launch_ff.vld && (llvl_ff == LVL_W'(g))) ? launch_ff : '0;
      end else begin : g_body
         assign cin[g] = (launch_ff.vld && (llvl_ff == LVL_W'(g))) ? launch_ff : cout[g-1];
      end

      lsegt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .level   (LVL_W'(g)),
         .in_tok  (cin[g]),
         .rd      (rdat[g]),
         .ram_req (creq[g]),
         .out_tok (cout[g]),
         .stat    (cst[g])
      );

      // clearing pass writes empty nodes everywhere
      always_comb begin
         if (st_ff == T_CLEAR) begin
            m_we    = 1'b1;
            m_re    = 1'b0;
            m_addr  = clr_ff[AW-1:0];
            m_wdata = '0;
         end else begin
            m_we    = creq[g].we;
            m_re    = creq[g].re;
            m_addr  = creq[g].addr[AW-1:0];
            m_wdata = creq[g].wdata;
         end
      end

      lsegt_ram #(
         .AW (AW),
         .DW ($bits(word_type))
      ) u_ram (
         .clock (clock),
         .we    (m_we),
         .re    (m_re),
         .addr  (m_addr),
         .wdata (m_wdata),
         .rdata (m_rdata)
      );

      assign rdat[g] = m_rdata;
   end

endmodule

@@ rtl/lsegt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsegt_ram
// single port node store with registered read data
// ----------------------------------------------------------------------------
module lsegt_ram #(
   parameter int AW = 1,
   parameter int DW = 8
) (
   input  logic          clock,
   input  logic          we,
   input  logic          re,
   input  logic [AW-1:0] addr,
   input  logic [DW-1:0] wdata,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [2**AW];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata <= mem[addr];
      end
   end

endmodule

@@ rtl/lsegt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsegt_cell
// one tree level: node update for inserts, line evaluation for queries
// ----------------------------------------------------------------------------
module lsegt_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [lsegt_pkg::LVL_W-1:0]   level,
   input  lsegt_pkg::tok_type            in_tok,
   input  lsegt_pkg::word_type           rd,
   output lsegt_pkg::ram_req_type        ram_req,
   output lsegt_pkg::tok_type            out_tok,
   output lsegt_pkg::cell_stat_type      stat
);
   import lsegt_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_FETCH = 6'b000010,
      ST_MUL   = 6'b000100,
      ST_CMP   = 6'b001000,
      ST_QMUL  = 6'b010000,
      ST_QADD  = 6'b100000
   } state_type;

   typedef enum logic [2:0] {
      PH_MID   = 3'b001,
      PH_LEFT  = 3'b010,
      PH_RIGHT = 3'b100
   } phase_type;

   state_type          st_ff, st_in;
   phase_type          ph_ff, ph_in;
   tok_type            tok_ff, tok_in;
   tok_type            out_ff, out_in;
   logic               done_ff, done_in;
   logic signed [31:0] wk_ff, wk_in;
   logic signed [62:0] wb_ff, wb_in;
   logic signed [32:0] dk_ff, dk_in;
   logic signed [63:0] db_ff, db_in;
   logic signed [54:0] prod_ff, prod_in;

   logic [LVL_W-1:0]   sh;
   logic [DOM_BITS:0]  span, node_l, node_r, node_m, xsel;
   logic signed [32:0] mul_a;
   logic signed [21:0] mul_c;
   logic signed [64:0] dsum;
   logic signed [63:0] qval;

   assign sh     = LEAF_LVL - level;
   assign span   = (DOM_BITS+1)'(1) << sh;
   assign node_l = (DOM_BITS+1)'(tok_ff.pos) << sh;
   assign node_r = node_l + span - (DOM_BITS+1)'(1);
   assign node_m = (sh == '0) ? node_l : node_l + (span >> 1) - (DOM_BITS+1)'(1);

   always_comb begin
      case (ph_ff)
         PH_MID:   xsel = node_m;
         PH_LEFT:  xsel = node_l;
         PH_RIGHT: xsel = node_r;
         default:  xsel = node_m;
      endcase
   end

   // one shared multiplier for both kinds of request
   always_comb begin
      if (st_ff == ST_QMUL) begin
         mul_a = 33'(rd.k);
         mul_c = signed'({2'b00, tok_ff.x});
      end else begin
         mul_a = dk_ff;
         mul_c = signed'({1'b0, xsel});
      end
   end

   assign dsum = 65'(prod_ff) + 65'(db_ff);
   assign qval = 64'(prod_ff) + 64'(rd.b);

   always_comb begin
      st_in   = st_ff;
      ph_in   = ph_ff;
      tok_in  = tok_ff;
      out_in  = '0;
      done_in = 1'b0;
      wk_in   = wk_ff;
      wb_in   = wb_ff;
      dk_in   = dk_ff;
      db_in   = db_ff;
      prod_in = prod_ff;
      ram_req = '0;
      ram_req.addr        = tok_ff.pos;
      ram_req.wdata.valid = 1'b1;
      ram_req.wdata.k     = tok_ff.k;
      ram_req.wdata.b     = tok_ff.b;
      case (st_ff)
         ST_IDLE: begin
            if (in_tok.vld) begin
               tok_in = in_tok;
               if (in_tok.qry) begin
                  tok_in.pos = in_tok.x >> sh;
               end
               ram_req.re   = 1'b1;
               ram_req.addr = tok_in.pos;
               st_in        = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (tok_ff.qry) begin
               if (rd.valid) begin
                  st_in = ST_QMUL;
               end else begin
                  out_in = tok_ff;
                  st_in  = ST_IDLE;
               end
            end else if (!rd.valid) begin
               // empty node takes the line
               ram_req.we = 1'b1;
               done_in    = 1'b1;
               st_in      = ST_IDLE;
            end else begin
               wk_in = rd.k;
               wb_in = rd.b;
               dk_in = 33'(tok_ff.k) - 33'(rd.k);
               db_in = 64'(tok_ff.b) - 64'(rd.b);
               ph_in = PH_MID;
               st_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in = 55'(mul_a) * 55'(mul_c);
            st_in   = ST_CMP;
         end
         ST_CMP: begin
            st_in = ST_MUL;
            case (ph_ff)
               PH_MID: begin
                  if (dsum[64]) begin
                     // new line wins at mid, the old one carries on
                     ram_req.we = 1'b1;
                     tok_in.k   = wk_ff;
                     tok_in.b   = wb_ff;
                     wk_in      = tok_ff.k;
                     wb_in      = tok_ff.b;
                     dk_in      = -dk_ff;
                     db_in      = -db_ff;
                  end
                  if (sh == '0) begin
                     done_in = 1'b1;
                     st_in   = ST_IDLE;
                  end else begin
                     ph_in = PH_LEFT;
                  end
               end
               PH_LEFT: begin
                  if (dsum[64]) begin
                     out_in     = tok_ff;
                     out_in.pos = {tok_ff.pos[DOM_BITS-2:0], 1'b0};
                     st_in      = ST_IDLE;
                  end else begin
                     ph_in = PH_RIGHT;
                  end
               end
               PH_RIGHT: begin
                  if (dsum[64]) begin
                     out_in     = tok_ff;
                     out_in.pos = {tok_ff.pos[DOM_BITS-2:0], 1'b1};
                  end else begin
                     done_in = 1'b1;
                  end
                  st_in = ST_IDLE;
               end
               default: begin
                  done_in = 1'b1;
                  st_in   = ST_IDLE;
               end
            endcase
         end
         ST_QMUL: begin
            prod_in = 55'(mul_a) * 55'(mul_c);
            st_in   = ST_QADD;
         end
         ST_QADD: begin
            out_in = tok_ff;
            if (!tok_ff.found || (qval < tok_ff.best)) begin
               out_in.best = qval;
            end
            out_in.found = 1'b1;
            st_in        = ST_IDLE;
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         out_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         out_ff  <= out_in;
         done_ff <= done_in;
      end
      ph_ff   <= ph_in;
      tok_ff  <= tok_in;
      wk_ff   <= wk_in;
      wb_ff   <= wb_in;
      dk_ff   <= dk_in;
      db_ff   <= db_in;
      prod_ff <= prod_in;
   end

   assign out_tok   = out_ff;
   assign stat.done = done_ff;

endmodule

@@ tb/min_line_segment_tree_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_line_segment_tree_core_test
// self-checking bench for the min-of-lines segment tree core
// ----------------------------------------------------------------------------
// drives insert and query requests with random gaps and stalls, keeps its own
// sparse copy of the tree and checks every query result against it
// ----------------------------------------------------------------------------
module min_line_segment_tree_core_test;
   import lsegt_pkg::*;

   // expected query outcome
   typedef struct {
      longint value;
      bit     found;
   } min_answer_type;

   // ------------------------------------------------------------------------
   // scoreboard: sparse tree model plus queue of pending query answers
   // ------------------------------------------------------------------------
   class min_tree_board;
      localparam int unsigned LAST_X     = DOMAIN_SIZE - 1;
      localparam int unsigned NODE_COUNT = 2 * DOMAIN_SIZE;

      longint         node_k[int unsigned];
      longint         node_b[int unsigned];
      min_answer_type answers[$];
      int             mismatches;
      int             checked;
      int             inserts;

      function longint line_value(longint k, longint b, longint x);
         return k * x + b;
      endfunction

      // push a line down from node u until it settles
      function void sink_line(int unsigned u, int unsigned l, int unsigned r,
                              longint k, longint b);
         int unsigned m;
         longint      ck, cb, tk, tb;
         forever begin
            if (u >= NODE_COUNT) return;
            if (!node_k.exists(u)) begin
               node_k[u] = k;
               node_b[u] = b;
               return;
            end
            m  = (l + r) >> 1;
            ck = node_k[u];
            cb = node_b[u];
            // strictly lower at mid wins the node
            if (line_value(k, b, m) < line_value(ck, cb, m)) begin
               node_k[u] = k;
               node_b[u] = b;
               tk = k; tb = b;
               k  = ck; b = cb;
               ck = tk; cb = tb;
            end
            if (l == r) return;
            if (line_value(k, b, l) < line_value(ck, cb, l)) begin
               u = u + 1;
               r = m;
            end else if (line_value(k, b, r) < line_value(ck, cb, r)) begin
               u = u + 2 * (m - l + 1);
               l = m + 1;
            end else begin
               return;
            end
         end
      endfunction

      function void place_segment(int unsigned u, int unsigned l, int unsigned r,
                                  int unsigned lo, int unsigned hi,
                                  longint k, longint b);
         int unsigned m;
         if (lo <= l && r <= hi) begin
            sink_line(u, l, r, k, b);
            return;
         end
         m = (l + r) >> 1;
         if (lo <= m) place_segment(u + 1, l, m, lo, hi, k, b);
         if (hi > m) place_segment(u + 2 * (m - l + 1), m + 1, r, lo, hi, k, b);
      endfunction

      function min_answer_type walk_min(int unsigned x);
         min_answer_type a;
         int unsigned    u, l, r, m;
         longint         v;
         a.value = NOT_FOUND_VALUE;
         a.found = 0;
         u = 0; l = 0; r = LAST_X;
         forever begin
            if (node_k.exists(u)) begin
               v = line_value(node_k[u], node_b[u], x);
               if (!a.found || v < a.value) a.value = v;
               a.found = 1;
            end
            if (l == r) break;
            m = (l + r) >> 1;
            if (x <= m) begin
               u = u + 1;
               r = m;
            end else begin
               u = u + 2 * (m - l + 1);
               l = m + 1;
            end
         end
         return a;
      endfunction

      // an accepted request
      function void note_request(logic act, logic [159:0] d);
         longint      k, b;
         int unsigned lo, hi;
         if (act == ACT_QUERY) begin
            answers.push_back(walk_min(d[154:135]));
         end else begin
            k  = longint'($signed(d[31:0]));
            b  = longint'($signed(d[94:32]));
            lo = d[114:95];
            hi = d[134:115];
            inserts++;
            if (hi > LAST_X) hi = LAST_X;
            if (lo <= hi) place_segment(0, 0, LAST_X, lo, hi, k, b);
         end
      endfunction

      // an accepted result
      function void check_result(logic [63:0] value, logic found);
         min_answer_type e;
         if (answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result with nothing pending: value %0d found %0b",
                        $signed(value), found);
            return;
         end
         e = answers.pop_front();
         checked++;
         if ($signed(value) !== e.value || found !== e.found) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected value %0d found %0b, got %0d found %0b",
                        e.value, e.found, $signed(value), found);
         end
      endfunction
   endclass

   localparam int ITEMS_PER_PHASE = 500;
   localparam int WATCHDOG_LIMIT  = 5_000_000;  // covers the clear pass after reset
   localparam int WINDOW          = 512;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;
   logic         req_tuser = ACT_INSERT;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [63:0]  rsp_tdata;
   logic         rsp_tuser;

   min_tree_board board = new();
   int            send_idle_pct;
   int            recv_stall_pct;
   int            idle_cycles = 0;
   int unsigned   window_base;

   always #5 clock = ~clock;

   min_line_segment_tree_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // receiver with random back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // request and result monitors
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) board.note_request(req_tuser, req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);
   end

   // watchdog: cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired, %0d results still pending", board.answers.size());
         $display("tb: failure");
         $finish;
      end
   end

   // present one request and hold it until accepted
   task automatic send_request(logic act, logic [159:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // unused fields are filled with noise
   task automatic insert_line(logic [31:0] k, logic [62:0] b, logic [19:0] lo,
                              logic [19:0] hi);
      send_request(ACT_INSERT, {5'b0, 20'($urandom), hi, lo, b, k});
   endtask

   task automatic query_at(logic [19:0] x);
      send_request(ACT_QUERY,
                   {5'b0, x, 20'($urandom), 20'($urandom), 63'({$urandom, $urandom}),
                    32'($urandom)});
   endtask

   function automatic logic [19:0] pick_point();
      if ($urandom_range(99) < 70) return 20'(window_base + $urandom_range(WINDOW - 1));
      return 20'($urandom);
   endfunction

   task automatic random_item();
      logic [31:0] k;
      logic [62:0] b;
      logic [19:0] lo, hi, t;
      int          sel;
      if ($urandom_range(99) < 50) begin
         query_at(pick_point());
         return;
      end
      // mostly small lines so that they compete inside the window
      if ($urandom_range(99) < 25) begin
         k = $urandom;
         b = 63'({$urandom, $urandom});
      end else begin
         k = 32'($signed($urandom_range(2000)) - 1000);
         b = 63'(longint'($urandom_range(2_000_000)) - 1_000_000);
      end
      sel = $urandom_range(99);
      lo  = pick_point();
      hi  = pick_point();
      if (sel < 85 && lo > hi) begin
         t = lo; lo = hi; hi = t;
      end else if (sel >= 95) begin
         lo = 0;
         hi = 20'hFFFFF;
      end
      insert_line(k, b, lo, hi);
   endtask

   task automatic drain();
      while (board.answers.size() != 0) @(posedge clock);
   endtask

   initial begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      window_base    = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty tree, extremes, ties, reversed and full segments
      query_at(20'h00000);
      query_at(20'hFFFFF);
      insert_line(32'h7FFFFFFF, 63'h3FFFFFFFFFFFFFFF, 20'd10, 20'd5);
      query_at(20'd7);
      insert_line(32'h80000000, 63'h3FFFFFFFFFFFFFFF, 20'h00000, 20'hFFFFF);
      query_at(20'hFFFFF);
      query_at(20'h00000);
      insert_line(32'h7FFFFFFF, 63'h4000000000000000, 20'd0, 20'd0);
      query_at(20'd0);
      insert_line(32'd5, 63'd100, 20'd100, 20'd200);
      insert_line(32'd5, 63'd100, 20'd100, 20'd200);
      insert_line(-32'sd5, 63'd1600, 20'd100, 20'd200);
      query_at(20'd100);
      query_at(20'd150);
      query_at(20'd200);
      insert_line(32'd0, -63'sd7, 20'hFFFFF, 20'hFFFFF);
      query_at(20'hFFFFF);
      query_at(20'hFFFFE);
      insert_line(32'd1, 63'd0, 20'h7FFFF, 20'h80000);
      query_at(20'h7FFFF);
      query_at(20'h80000);
      req_tvalid <= 1'b0;
      @(posedge clock);

      // random phases: none, sender gaps, receiver stalls, both
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 7 : 48) : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 7 : 48) : 0;
         window_base    = $urandom_range(DOMAIN_SIZE - WINDOW);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) random_item();
         req_tvalid <= 1'b0;
         @(posedge clock);
      end

      drain();
      repeat (300) @(posedge clock);
      $display("covered %0d inserts and %0d query results over four idling mixes",
               board.inserts, board.checked);
      if (board.mismatches == 0 && board.answers.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches, %0d results missing", board.mismatches,
                  board.answers.size());
         $display("tb: failure");
      end
      $finish;
   end

endmodule
